// ----- sv/assert_macros.svh -----
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EDMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("edma assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define EDMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("edma assertion failed: next-cycle implication");

`endif

// ----- sv/edma_pkg.sv -----
// Package: widths, constants and FSM state type of the echo distance filter.
package edma_pkg;

    localparam int ECHO_W   = 15;
    localparam int DIST_W   = 16;
    localparam int SCALED_W = 20;   // echo * 17 fits here
    localparam int PROD_W   = 2 * SCALED_W;

    // floor(x / 10) == (x * RECIP_MULT) >> RECIP_SHIFT for x < 2**22
    localparam logic [SCALED_W-1:0] RECIP_MULT  = 20'd838861;
    localparam int                  RECIP_SHIFT = 23;

    localparam logic [DIST_W-1:0] THRESH_RESET = 16'd3000;
    localparam logic [DIST_W-1:0] DIST_MAX     = 16'd55703;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_UPDATE,
        S_DIVIDE,
        S_DONE
    } state_t;

endpackage

// ----- sv/edma_if.sv -----
// Request and result channel interfaces of the echo distance filter.
interface edma_echo_if;
    logic                            valid;
    logic                            ready;
    logic [edma_pkg::ECHO_W-1:0]     echo_time_us;
    logic                            link_connected;

    modport source (output valid, echo_time_us, link_connected, input ready);
    modport sink   (input valid, echo_time_us, link_connected, output ready);
endinterface

interface edma_report_if;
    logic                            valid;
    logic                            ready;
    logic [edma_pkg::DIST_W-1:0]     raw_distance;
    logic [edma_pkg::DIST_W-1:0]     filtered_distance;
    logic                            notify;

    modport source (output valid, raw_distance, filtered_distance, notify, input ready);
    modport sink   (input valid, raw_distance, filtered_distance, notify, output ready);
endinterface

// ----- sv/edma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module edma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 5
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/echo_distance_moving_average_top.sv -----
// Top level: echo time to distance, ring-buffer moving average, notify flag.
//
//  channel  | dir | payload                                        | request when
//  ---------+-----+------------------------------------------------+------------------
//  echo     | in  | echo_time_us[14:0], link_connected              | valid & ready
//  report   | out | raw_distance[15:0], filtered_distance[15:0],    | valid & ready
//           |     | notify                                         |
//  wr_en/   | in  | notify_threshold[15:0]                         | wr_en high
//  wr_data  |     |                                                |
//
// One request at a time: a new request is taken only in S_IDLE, once the last one
// has passed S_SCALE, S_UPDATE, the bit-serial divider in S_DIVIDE (one quotient
// bit per cycle over the SUM_W-bit sum) and S_DONE. rst_n clears the FSM, slot
// pointer, fill flag, sum and report valid, and sets the threshold to 3000; the
// sample RAM is not cleared: slots read before the ring has wrapped count as zero.
// A held report does not block the next request; only its completion waits.
module echo_distance_moving_average_top #(
    parameter int WINDOW = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    edma_echo_if.sink                   echo,
    edma_report_if.source               report,
    input  logic                        wr_en,
    input  logic [edma_pkg::DIST_W-1:0] wr_data
);

    // Derived widths
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = edma_pkg::DIST_W + $clog2(WINDOW);
    localparam int ITER_W = $clog2(SUM_W);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    edma_pkg::state_t state_reg, state_next;

    logic [edma_pkg::DIST_W-1:0]   thresh_reg;
    logic [SLOT_W-1:0]             slot_reg;
    logic                          full_reg;
    logic [SUM_W-1:0]              sum_reg;

    // Per-request working registers (payload, no reset)
    logic [edma_pkg::SCALED_W-1:0] x17_reg;
    logic                          link_reg;
    logic [edma_pkg::DIST_W-1:0]   dist_reg;
    logic [edma_pkg::DIST_W-1:0]   old_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [SUM_W-1:0]              quo_reg;
    logic [CNT_W:0]                rem_reg;
    logic [ITER_W-1:0]             iter_reg;

    // Output register
    logic                          out_valid_reg;
    logic [edma_pkg::DIST_W-1:0]   out_raw_reg;
    logic [edma_pkg::DIST_W-1:0]   out_mean_reg;
    logic                          out_notify_reg;

    // ------------------------------------------------------------------
    // Control decodes
    // ------------------------------------------------------------------
    logic echo_req;
    logic out_free;
    logic div_last;
    logic ram_we;
    logic out_load;

    assign echo_req = echo.valid && echo.ready;
    assign out_free = !out_valid_reg || report.ready;
    assign div_last = (iter_reg == ITER_W'(SUM_W - 1));

    // ------------------------------------------------------------------
    // Sample ring: read old slot at request, write new distance in S_UPDATE
    // ------------------------------------------------------------------
    logic [edma_pkg::DIST_W-1:0] ram_rdata;

    edma_ram #(
        .WIDTH (edma_pkg::DIST_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (dist_reg),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Datapath combinational terms
    // ------------------------------------------------------------------
    logic [edma_pkg::SCALED_W-1:0] x17_next;
    logic [edma_pkg::PROD_W-1:0]   prod;
    logic                          wrap;
    logic [CNT_W-1:0]              count_next;
    logic [SUM_W-1:0]              sum_next;
    logic [CNT_W:0]                rem_sh;
    logic                          rem_ge;
    logic [edma_pkg::DIST_W-1:0]   mean;

    // echo * 17 as shift-add
    assign x17_next = edma_pkg::SCALED_W'(echo.echo_time_us)
                    + (edma_pkg::SCALED_W'(echo.echo_time_us) << 4);

    // divide by 10 through a reciprocal multiply
    assign prod = edma_pkg::PROD_W'(x17_reg) * edma_pkg::PROD_W'(edma_pkg::RECIP_MULT);

    assign wrap       = (slot_reg == SLOT_W'(WINDOW - 1));
    assign count_next = (wrap || full_reg) ? CNT_W'(WINDOW)
                                           : CNT_W'(slot_reg) + CNT_W'(1);
    assign sum_next   = sum_reg - SUM_W'(old_reg) + SUM_W'(dist_reg);

    // restoring divider step; remainder stays below count before the shift
    assign rem_sh = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, count_reg});
    assign mean   = quo_reg[edma_pkg::DIST_W-1:0];

    // ------------------------------------------------------------------
    // FSM next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            edma_pkg::S_IDLE:
            begin
                if (echo.valid)
                begin
                    state_next = edma_pkg::S_SCALE;
                end
            end
            edma_pkg::S_SCALE:  state_next = edma_pkg::S_UPDATE;
            edma_pkg::S_UPDATE: state_next = edma_pkg::S_DIVIDE;
            edma_pkg::S_DIVIDE:
            begin
                if (div_last)
                begin
                    state_next = edma_pkg::S_DONE;
                end
            end
            edma_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = edma_pkg::S_IDLE;
                end
            end
            default: state_next = edma_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // FSM outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        echo.ready = 1'b0;
        ram_we     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            edma_pkg::S_IDLE:   echo.ready = 1'b1;
            edma_pkg::S_UPDATE: ram_we     = 1'b1;
            edma_pkg::S_DONE:   out_load   = out_free;
            default:
            begin
                echo.ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= edma_pkg::S_IDLE;
            thresh_reg    <= edma_pkg::THRESH_RESET;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                thresh_reg <= wr_data;
            end
            if (ram_we)
            begin
                sum_reg  <= sum_next;
                slot_reg <= wrap ? '0 : slot_reg + SLOT_W'(1);
                if (wrap)
                begin
                    full_reg <= 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Working registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (echo_req)
        begin
            x17_reg  <= x17_next;
            link_reg <= echo.link_connected;
        end
        if (state_reg == edma_pkg::S_SCALE)
        begin
            dist_reg <= prod[edma_pkg::RECIP_SHIFT +: edma_pkg::DIST_W];
            // before the ring first wraps, the slot was never written: zero
            old_reg  <= full_reg ? ram_rdata : '0;
        end
        if (ram_we)
        begin
            count_reg <= count_next;
            quo_reg   <= sum_next;
            rem_reg   <= '0;
            iter_reg  <= '0;
        end
        if (state_reg == edma_pkg::S_DIVIDE)
        begin
            rem_reg  <= rem_ge ? rem_sh - {1'b0, count_reg} : rem_sh;
            quo_reg  <= {quo_reg[SUM_W-2:0], rem_ge};
            iter_reg <= iter_reg + ITER_W'(1);
        end
        if (out_load)
        begin
            out_raw_reg    <= dist_reg;
            out_mean_reg   <= mean;
            out_notify_reg <= link_reg && (mean < thresh_reg);
        end
    end

    assign report.valid             = out_valid_reg;
    assign report.raw_distance      = out_raw_reg;
    assign report.filtered_distance = out_mean_reg;
    assign report.notify            = out_notify_reg;

endmodule

// ----- sv/edma_checker.sv -----
// Port-level checker for the echo distance filter, bound to the top level.
`include "assert_macros.svh"

module edma_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [edma_pkg::DIST_W-1:0] raw_distance,
    input logic [edma_pkg::DIST_W-1:0] filtered_distance,
    input logic                        notify
);

    logic in_req;
    assign in_req = in_valid && in_ready;

    // a held report keeps its payload
    `EDMA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(raw_distance) && $stable(filtered_distance) && $stable(notify))

    // one request in flight at a time
    `EDMA_ASSERT_NEXT(a_busy, clk, rst_n, in_req, !in_ready)

    // no report appears the cycle after a request
    `EDMA_ASSERT_NEXT(a_latency, clk, rst_n, in_req, !$rose(out_valid))

    // scaled distance never exceeds the largest 15-bit echo times 1.7
    `EDMA_ASSERT_IMPLY(a_range, clk, rst_n, out_valid, (raw_distance <= edma_pkg::DIST_MAX) && (filtered_distance <= edma_pkg::DIST_MAX))

endmodule

bind echo_distance_moving_average_top edma_checker u_edma_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (echo.valid),
    .in_ready          (echo.ready),
    .out_valid         (report.valid),
    .out_ready         (report.ready),
    .raw_distance      (report.raw_distance),
    .filtered_distance (report.filtered_distance),
    .notify            (report.notify)
);

// ----- dv/echo_distance_moving_average_top_tb.sv -----
// Testbench for the echo distance moving-average filter: random and directed requests, self-checking.
module echo_distance_moving_average_top_tb;

    localparam int AVG_WINDOW    = 5;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 7;
    // Extra wait after draining so the block is idle again; leave margin.
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_PRINTED   = 40;
    localparam int PHASE_ITEMS   = 140;
    localparam int NUM_PHASES    = 8;

    typedef struct {
        logic [edma_pkg::ECHO_W-1:0] echo_us;
        logic                        link;
    } echo_req_t;

    typedef struct {
        logic [edma_pkg::DIST_W-1:0] raw;
        logic [edma_pkg::DIST_W-1:0] filtered;
        logic                        notify;
    } dist_report_t;

    logic                        clk;
    logic                        rst_n;
    logic                        wr_en;
    logic [edma_pkg::DIST_W-1:0] wr_data;

    edma_echo_if   echo_ch ();
    edma_report_if report_ch ();

    echo_distance_moving_average_top #(
        .WINDOW (AVG_WINDOW)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .echo    (echo_ch),
        .report  (report_ch),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    // Shadow of the filter: sample ring, write pointer, fill flag, running sum,
    // and the notify threshold register.
    logic [edma_pkg::DIST_W-1:0] ring_shadow [AVG_WINDOW];
    int unsigned                 slot_shadow;
    bit                          full_shadow;
    int unsigned                 sum_shadow;
    logic [edma_pkg::DIST_W-1:0] thresh_shadow;

    echo_req_t    echo_backlog [$];   // requests not yet offered to the block
    dist_report_t pending_reports [$]; // predicted reports, oldest first
    echo_req_t    in_flight;          // request currently offered on the echo channel

    int unsigned n_queued;
    int unsigned n_accepted;
    int          err_count;

    // Calm phases run both sides with no idle cycles at all.
    bit          sender_calm;
    bit          sink_calm;
    int unsigned send_gap;
    int unsigned sink_stall;

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int unsigned pick_idle(bit calm);
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        if (roll < 98)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Advance the shadow filter by one echo and return the report it owes.
    // Distance is echo * 17 / 10 (hundredths of cm); the mean divides by the
    // number of samples stored so far, capped at the window size.
    function automatic dist_report_t predict_distance_report(echo_req_t req);
        dist_report_t rep;
        int unsigned  distance;
        int unsigned  count;
        int unsigned  mean;
        distance = 32'(req.echo_us);
        distance = (distance * 17) / 10;
        // evict the oldest sample (zero until the ring has wrapped)
        sum_shadow = sum_shadow - ring_shadow[slot_shadow] + distance;
        ring_shadow[slot_shadow] = distance[edma_pkg::DIST_W-1:0];
        slot_shadow++;
        if (slot_shadow == AVG_WINDOW)
        begin
            slot_shadow = 0;
            full_shadow = 1'b1;
        end
        count = full_shadow ? AVG_WINDOW : slot_shadow;
        mean = sum_shadow / count;
        rep.raw      = distance[edma_pkg::DIST_W-1:0];
        rep.filtered = mean[edma_pkg::DIST_W-1:0];
        rep.notify   = req.link && (mean < thresh_shadow);
        return rep;
    endfunction

    task automatic flag_mismatch(string msg);
        if (err_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // Driver: offers backlog requests, inserting random gaps between them.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            echo_ch.valid <= 1'b0;
        end
        else
        begin
            if (echo_ch.valid && echo_ch.ready)
            begin
                pending_reports.push_back(predict_distance_report(in_flight));
                n_accepted++;
            end
            // valid may only change once the current request is taken
            if (!echo_ch.valid || echo_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    echo_ch.valid <= 1'b0;
                end
                else if (echo_backlog.size() > 0)
                begin
                    in_flight = echo_backlog.pop_front();
                    echo_ch.valid          <= 1'b1;
                    echo_ch.echo_time_us   <= in_flight.echo_us;
                    echo_ch.link_connected <= in_flight.link;
                    send_gap = pick_idle(sender_calm);
                end
                else
                begin
                    echo_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each taken report against the oldest prediction and
    // throttles ready at random.
    always @(posedge clk)
    begin
        dist_report_t want;
        if (!rst_n)
        begin
            report_ch.ready <= 1'b0;
        end
        else
        begin
            if (report_ch.valid && report_ch.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    flag_mismatch($sformatf("report raw=%0d filtered=%0d with none pending",
                                            report_ch.raw_distance,
                                            report_ch.filtered_distance));
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (report_ch.raw_distance !== want.raw)
                        flag_mismatch($sformatf("raw_distance got %0d want %0d",
                                                report_ch.raw_distance, want.raw));
                    if (report_ch.filtered_distance !== want.filtered)
                        flag_mismatch($sformatf("filtered_distance got %0d want %0d",
                                                report_ch.filtered_distance, want.filtered));
                    if (report_ch.notify !== want.notify)
                        flag_mismatch($sformatf("notify got %0b want %0b",
                                                report_ch.notify, want.notify));
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                report_ch.ready <= 1'b0;
            end
            else
            begin
                report_ch.ready <= 1'b1;
                if ($urandom_range(3) == 0)
                    sink_stall = pick_idle(sink_calm);
            end
        end
    end

    task automatic queue_echo(int unsigned echo_us, bit link);
        echo_req_t req;
        req.echo_us = echo_us[edma_pkg::ECHO_W-1:0];
        req.link    = link;
        echo_backlog.push_back(req);
        n_queued++;
    endtask

    // Block until every request is taken and every report checked, then let
    // the pipeline settle so the block is idle.
    task automatic wait_drained();
        while (n_accepted != n_queued || pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called with the block idle, so the shadow threshold can switch now.
    task automatic write_threshold(logic [edma_pkg::DIST_W-1:0] value);
        @(posedge clk);
        wr_en   <= 1'b1;
        wr_data <= value;
        thresh_shadow = value;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // Echo mix: timeouts, over-range echoes, tiny values, values whose
    // distance lands right around the threshold, and the full field.
    function automatic int unsigned random_echo(int unsigned thr);
        int unsigned roll;
        int          near;
        roll = $urandom_range(99);
        if (roll < 8)
            return 0;
        if (roll < 16)
            return $urandom_range(32767, 30001);
        if (roll < 26)
            return $urandom_range(20);
        if (roll < 46)
        begin
            near = (thr * 10) / 17 + $urandom_range(6) - 3;
            if (near < 0)
                near = 0;
            if (near > 32767)
                near = 32767;
            return near;
        end
        return $urandom_range(32767);
    endfunction

    initial
    begin
        logic [edma_pkg::DIST_W-1:0] phase_thresh [NUM_PHASES];
        int unsigned                 thr;

        rst_n                  = 1'b0;
        wr_en                  = 1'b0;
        wr_data                = '0;
        echo_ch.valid          = 1'b0;
        echo_ch.echo_time_us   = '0;
        echo_ch.link_connected = 1'b0;
        report_ch.ready        = 1'b0;
        foreach (ring_shadow[i])
            ring_shadow[i] = '0;
        slot_shadow   = 0;
        full_shadow   = 1'b0;
        sum_shadow    = 0;
        thresh_shadow = edma_pkg::THRESH_RESET;
        n_queued      = 0;
        n_accepted    = 0;
        err_count     = 0;
        sender_calm   = 1'b0;
        sink_calm     = 1'b0;
        send_gap      = 0;
        sink_stall    = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset threshold of 3000. The first five
        // exercise warm-up (divisor 1..5), the rest wrap the ring.
        queue_echo(0, 1);          // timeout echo, stored as distance 0
        queue_echo(0, 0);
        queue_echo(1, 1);
        queue_echo(32767, 1);      // largest field value: 55703, no saturation
        queue_echo(30000, 0);      // top of the sensor's range
        queue_echo(1765, 1);       // distance exactly 3000
        queue_echo(1765, 1);
        queue_echo(1765, 1);
        queue_echo(1765, 1);
        queue_echo(1765, 1);       // mean == threshold: notify stays low
        queue_echo(1764, 1);       // 2998: mean drops just below threshold
        queue_echo(1764, 0);       // same, link down
        queue_echo(10, 1);
        queue_echo(9, 0);
        queue_echo(15'h5555, 1);
        queue_echo(15'h2AAA, 0);
        queue_echo(15'h7FFF, 1);
        queue_echo(15'h4000, 1);
        queue_echo(17, 1);
        queue_echo(0, 1);
        queue_echo(0, 1);
        queue_echo(0, 1);
        wait_drained();

        // Threshold per phase: both extremes, one, values straddling the largest
        // distance, the reset value and random ones.
        phase_thresh[0] = 16'hFFFF;
        phase_thresh[1] = 16'h0000;
        phase_thresh[2] = 16'($urandom_range(65535));
        phase_thresh[3] = 16'd1;
        phase_thresh[4] = edma_pkg::DIST_MAX;
        phase_thresh[5] = 16'($urandom_range(20000));
        phase_thresh[6] = edma_pkg::DIST_MAX + 16'd1;
        phase_thresh[7] = edma_pkg::THRESH_RESET;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_threshold(phase_thresh[p]);
            thr = 32'(phase_thresh[p]);
            // every third phase runs back to back on both sides
            sender_calm = (p % 3 == 1);
            sink_calm   = (p % 3 == 1);
            for (int i = 0; i < PHASE_ITEMS / 2; i++)
                queue_echo(random_echo(thr), 1'($urandom_range(1)));
            // on even phases the sender holds off mid-phase until every report is back
            if (p % 2 == 0)
                wait_drained();
            for (int i = 0; i < PHASE_ITEMS / 2; i++)
                queue_echo(random_echo(thr), 1'($urandom_range(1)));
            wait_drained();
        end

        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #12000000;
        $display("status: fail");
        $finish;
    end

endmodule
